/* hdl/ltm_pkg.sv */
package ltm_pkg;

  // Number of samples carried by one input word and channels per sample.
  localparam int LANES    = 8;
  localparam int CHANNELS = 8;

  localparam int SAMPLE_W = 8;
  localparam int WORD_W   = 64;
  localparam int LANE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Channels at or above CHANNELS take no part in the match.
  localparam logic [SAMPLE_W-1:0] CH_USED_BITS = SAMPLE_W'((1 << CHANNELS) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_MASK     = 2'd0,
    CFG_CHANGE_MASK    = 2'd1,
    CFG_EXPECTED_LEVEL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level_mask;
    logic [SAMPLE_W-1:0] change_mask;
    logic [SAMPLE_W-1:0] expected_level;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample_word;
    logic              restart;
  } in_t;

  typedef struct packed {
    logic              trigger_hit;
    logic [LANE_W-1:0] hit_lane;
    logic              fired;
  } out_t;

endpackage

/* hdl/ltm_lane.sv */
module ltm_lane (
  input  ltm_pkg::cfg_t                      cfg,
  input  logic [ltm_pkg::SAMPLE_W-1:0]       cur,
  input  logic [ltm_pkg::SAMPLE_W-1:0]       prev,
  output logic                               match
);
  import ltm_pkg::*;

  logic [SAMPLE_W-1:0] bad_level;
  logic [SAMPLE_W-1:0] bad_change;

  // A channel fails when its level is wrong, or when it was asked to change and did not.
  assign bad_level  = (cur ^ cfg.expected_level) & cfg.level_mask;
  assign bad_change = ~(cur ^ prev) & cfg.change_mask;
  assign match      = ((bad_level | bad_change) & CH_USED_BITS) == '0;

endmodule

/* hdl/ltm_merge.sv */
module ltm_merge (
  input  logic [ltm_pkg::LANES-1:0] lane_match,
  input  logic                      fired_r,
  input  logic                      restart,
  output ltm_pkg::out_t             result
);
  import ltm_pkg::*;

  logic              armed;
  logic              any_match;
  logic [LANE_W-1:0] first_lane;

  assign armed     = !fired_r || restart;
  assign any_match = |lane_match;

  // Scan from the latest lane down so that the earliest match wins.
  always_comb begin
    first_lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lane_match[i]) begin
        first_lane = LANE_W'(i);
      end
    end
  end

  always_comb begin
    result.trigger_hit = armed && any_match;
    result.hit_lane    = (armed && any_match) ? first_lane : '0;
    result.fired       = !armed || any_match;
  end

endmodule

/* hdl/ltm_obuf.sv */
module ltm_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ltm_pkg::out_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output ltm_pkg::out_t out_data
);
  import ltm_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t main_data_r, main_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic take;

  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

/* hdl/logic_trigger_matcher.sv */
// Each result is registered, in the output register or in the skid register behind it.
// Throughput: one request per cycle while in_stall is low; all eight sample lanes are checked in the same cycle.
// The input stalls only when both the output register and the skid register are full.
// Reset (rst_n low, synchronous) clears the configuration registers, the last sample,
// the fired flag and both output valid bits.
module logic_trigger_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ltm_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ltm_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [ltm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ltm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ltm_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  logic [SAMPLE_W-1:0] last_sample_r, last_sample_nxt;
  logic                fired_r, fired_nxt;
  logic                in_accept;
  logic                buf_full;
  logic [LANES-1:0]    lane_match;
  out_t                result;

  // The configuration port writes one register per enabled cycle. An index
  // past the last register is simply dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL_MASK:     cfg_nxt.level_mask     = cfg_wdata;
        CFG_CHANGE_MASK:    cfg_nxt.change_mask    = cfg_wdata;
        CFG_EXPECTED_LEVEL: cfg_nxt.expected_level = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  // One comparator per sample lane. Lane 0 compares against the last sample of
  // the previous word; every other lane compares against its lower neighbor.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] prev;

    assign cur = in_data.sample_word[g*SAMPLE_W +: SAMPLE_W] & CH_USED_BITS;

    if (g == 0) begin : g_first
      assign prev = last_sample_r;
    end else begin : g_rest
      assign prev = in_data.sample_word[(g-1)*SAMPLE_W +: SAMPLE_W] & CH_USED_BITS;
    end

    ltm_lane u_lane (
      .cfg   (cfg_r),
      .cur   (cur),
      .prev  (prev),
      .match (lane_match[g])
    );
  end

  // The merge stage picks the earliest matching lane and applies the latched
  // fired flag, which a restart in the same request clears first.
  ltm_merge u_merge (
    .lane_match (lane_match),
    .fired_r    (fired_r),
    .restart    (in_data.restart),
    .result     (result)
  );

  // The last sample tracks every accepted word, even after the trigger fired,
  // so that edge conditions stay correct after a restart.
  always_comb begin
    last_sample_nxt = last_sample_r;
    fired_nxt       = fired_r;
    if (in_accept) begin
      last_sample_nxt = in_data.sample_word[(LANES-1)*SAMPLE_W +: SAMPLE_W] & CH_USED_BITS;
      fired_nxt       = result.fired;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= '0;
      last_sample_r <= '0;
      fired_r       <= 1'b0;
    end else begin
      cfg_r         <= cfg_nxt;
      last_sample_r <= last_sample_nxt;
      fired_r       <= fired_nxt;
    end
  end

  // Output register with a skid stage behind it, so a stalled result does not
  // block the request that arrives in the same cycle.
  ltm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/ltm_checker.sv */
module ltm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input ltm_pkg::out_t                  out_data
);
  import ltm_pkg::*;

  // A hit always leaves the trigger latched.
  a_hit_sets_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.trigger_hit |-> out_data.fired)
    else $error("trigger hit reported without fired status");

  // Without a hit the lane field reads zero.
  a_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.trigger_hit |-> out_data.hit_lane == '0)
    else $error("hit lane nonzero without a hit");

  // A request that enters on a free path is valid at the output in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !(out_valid && out_stall) |=> out_valid)
    else $error("accepted request did not reach the output");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind logic_trigger_matcher ltm_checker u_ltm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ltm_pkg::*;

  // The only register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // The block registers each result before it answers; the settle wait covers the
  // skid register as well.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SEGMENT_REQS  = 50;
  localparam int PRINT_LIMIT   = 30;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  logic  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic_trigger_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a copy of the trigger registers, the sample that precedes
  // the next word and the latched fired flag.
  cfg_t                trig_cfg;
  logic [SAMPLE_W-1:0] last_smp;
  logic                fired_q;

  // Results that the predictor has worked out and that have not yet come back.
  out_t pending_results[$];
  out_t want_res;

  int errors = 0;
  int reqs_sent = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int cycles = 0;

  // Idle rates in percent, and the remaining length of a long receiver hold-off.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A run that hangs on a handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // The hold-off is counted down here; the stall process only looks at it.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall: random at the phase rate, or held high during a hold-off.
  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_LIMIT) begin
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    end
    errors++;
  endtask

  // Works out the result of one request and advances the predictor state.
  // A fired trigger skips the search but still tracks the last sample, so that
  // edges right after a restart are judged against the true previous sample.
  function automatic out_t predict_trigger(input in_t req);
    out_t                res;
    logic [SAMPLE_W-1:0] prev_s;
    logic [SAMPLE_W-1:0] cur_s;
    logic [SAMPLE_W-1:0] miss;
    logic                found;
    res = '0;
    found = 1'b0;
    prev_s = last_smp;
    if (req.restart) begin
      fired_q = 1'b0;
    end
    if (!fired_q) begin
      for (int i = 0; i < LANES; i++) begin
        cur_s = req.sample_word[SAMPLE_W*i +: SAMPLE_W] & CH_USED_BITS;
        miss = ((cur_s ^ trig_cfg.expected_level) & trig_cfg.level_mask)
             | (~(cur_s ^ prev_s) & trig_cfg.change_mask);
        if (!found && (miss & CH_USED_BITS) == '0) begin
          found = 1'b1;
          res.hit_lane = LANE_W'(i);
        end
        prev_s = cur_s;
      end
      fired_q = found;
    end
    res.trigger_hit = found;
    res.fired = fired_q;
    last_smp = req.sample_word[SAMPLE_W*(LANES-1) +: SAMPLE_W] & CH_USED_BITS;
    return res;
  endfunction

  // Each accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 1, 0);
      end else begin
        want_res = pending_results.pop_front();
        results_checked++;
        if (out_data.trigger_hit) begin
          hits_seen++;
        end
        if (out_data.trigger_hit !== want_res.trigger_hit) begin
          report_mismatch("trigger_hit", int'(out_data.trigger_hit),
                          int'(want_res.trigger_hit));
        end
        if (out_data.hit_lane !== want_res.hit_lane) begin
          report_mismatch("hit_lane", int'(out_data.hit_lane), int'(want_res.hit_lane));
        end
        if (out_data.fired !== want_res.fired) begin
          report_mismatch("fired", int'(out_data.fired), int'(want_res.fired));
        end
      end
    end
  end

  // Offers one request and waits for the handshake. The valid stays high on
  // return unless a sender gap is drawn, so back-to-back requests need no
  // second assignment in one time step.
  task automatic send_request(input logic [WORD_W-1:0] word, input logic restart);
    in_valid <= 1'b1;
    in_data <= '{sample_word: word, restart: restart};
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_trigger('{sample_word: word, restart: restart}));
    reqs_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three trigger registers with the write enable held high.
  task automatic program_trigger(input logic [SAMPLE_W-1:0] lvl_mask,
                                 input logic [SAMPLE_W-1:0] chg_mask,
                                 input logic [SAMPLE_W-1:0] exp_lvl);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_LEVEL_MASK;
    cfg_wdata <= lvl_mask;
    @(posedge clk);
    cfg_index <= CFG_CHANGE_MASK;
    cfg_wdata <= chg_mask;
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_LEVEL;
    cfg_wdata <= exp_lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_cfg.level_mask = lvl_mask;
    trig_cfg.change_mask = chg_mask;
    trig_cfg.expected_level = exp_lvl;
  endtask

  task automatic test_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    trig_cfg = '0;
    last_smp = '0;
    fired_q = 1'b0;
    @(posedge clk);
  endtask

  // With nothing masked every sample matches, so the first word fires on lane 0.
  // Once fired, no further hit appears until a restart.
  task automatic test_empty_masks();
    program_trigger(8'h00, 8'h00, 8'h00);
    send_request(64'h0, 1'b0);
    send_request({WORD_W{1'b1}}, 1'b0);
    send_request({WORD_W{1'b1}}, 1'b1);
    send_request(64'h0, 1'b0);
  endtask

  // Full level match on a pattern that sits in the middle of the word.
  task automatic test_levels();
    program_trigger(8'hFF, 8'h00, 8'hA5);
    send_request(64'h0000_A500_0000_0000, 1'b1);
    send_request(64'h0, 1'b1);
    send_request({WORD_W{1'b1}}, 1'b1);
    program_trigger(8'hFF, 8'h00, 8'hFF);
    send_request({WORD_W{1'b1}}, 1'b1);
  endtask

  // Rising, falling and any-edge conditions, including an edge between the
  // last sample of one word and the first of the next, and an edge right
  // after a restart that follows a word seen while fired.
  task automatic test_edges();
    program_trigger(8'h01, 8'h01, 8'h01);
    send_request(64'h0000_0000_0000_0000, 1'b1);
    send_request(64'h0101_0101_0101_0101, 1'b1);
    send_request(64'h0101_0100_0000_0000, 1'b1);
    program_trigger(8'h80, 8'h80, 8'h00);
    send_request(64'h8000_0000_0000_0000, 1'b1);
    send_request(64'h0000_0000_0000_0000, 1'b0);
    send_request(64'h8000_0000_0000_0000, 1'b0);
    send_request(64'h0080_8080_8080_8080, 1'b1);
    program_trigger(8'h00, 8'h10, 8'h00);
    send_request(64'h1010_1010_1010_1010, 1'b1);
    send_request(64'h0000_0000_0000_0000, 1'b1);
  endtask

  // A write to the undecoded index must leave the trigger registers alone.
  task automatic test_unused_index();
    program_trigger(8'hFF, 8'h00, 8'h00);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_UNUSED;
    cfg_wdata <= 8'hFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_request(64'h0, 1'b1);
    send_request({WORD_W{1'b1}}, 1'b1);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_mask();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Builds a request. Most words carry one sample that is made to satisfy the
  // current trigger, at a random lane, so that hits land on every lane; the
  // rest are random or flat words.
  function automatic in_t make_request();
    in_t                 req;
    logic [SAMPLE_W-1:0] prev_s;
    logic [SAMPLE_W-1:0] cur_s;
    int                  lane;
    req.sample_word = {$urandom, $urandom};
    req.restart = fired_q ? ($urandom_range(1) == 0) : ($urandom_range(7) == 0);
    case ($urandom_range(9))
      6, 7, 8: ;
      9: req.sample_word = {LANES{SAMPLE_W'($urandom_range(1) ? 8'hFF : 8'h00)}};
      default: begin
        lane = $urandom_range(LANES - 1);
        prev_s = (lane == 0) ? last_smp : req.sample_word[SAMPLE_W*(lane-1) +: SAMPLE_W];
        cur_s = (SAMPLE_W'($urandom) & ~(trig_cfg.level_mask | trig_cfg.change_mask))
              | (trig_cfg.expected_level & trig_cfg.level_mask)
              | (~prev_s & trig_cfg.change_mask & ~trig_cfg.level_mask);
        req.sample_word[SAMPLE_W*lane +: SAMPLE_W] = cur_s;
      end
    endcase
    return req;
  endfunction

  // Random traffic under one idle setting; the trigger is reprogrammed with
  // the block idle at the start of every segment.
  task automatic test_random_phase(input int send_pct, input int recv_pct, input int segments);
    in_t req;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (int s = 0; s < segments; s++) begin
      program_trigger(pick_mask(), pick_mask(), pick_mask());
      for (int n = 0; n < SEGMENT_REQS; n++) begin
        req = make_request();
        send_request(req.sample_word, req.restart);
      end
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // both output registers fill and the input stalls; then the sender pauses
  // until everything has drained.
  task automatic test_backpressure();
    in_t req;
    send_idle_pct = 0;
    stall_pct = 0;
    program_trigger(8'h0F, 8'h03, 8'h05);
    hold_left = 300;
    for (int n = 0; n < 40; n++) begin
      req = make_request();
      send_request(req.sample_word, req.restart);
    end
    wait_idle();
  endtask

  initial begin
    test_reset();
    test_empty_masks();
    test_levels();
    test_edges();
    test_unused_index();
    test_backpressure();
    test_random_phase(0, 0, 5);
    test_random_phase(52, 0, 5);
    test_random_phase(0, 52, 5);
    test_random_phase(25, 25, 5);
    wait_idle();
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 0, pending_results.size());
    end
    $display("Ran %0d requests (%0d results checked, %0d trigger hits) over level, edge,",
             reqs_sent, results_checked, hits_seen);
    $display("restart, undecoded-index, long hold-off and random idle/stall phases.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* logic_trigger_matcher.f */
hdl/ltm_pkg.sv
hdl/ltm_lane.sv
hdl/ltm_merge.sv
hdl/ltm_obuf.sv
hdl/logic_trigger_matcher.sv
hdl/ltm_checker.sv
tb/tb_top.sv
